// ----- hw/rtl/stnl_pkg.sv -----
// Shared types, codes and constants of the nearest-symbol lookup table.
`timescale 1ns / 1ps
package stnl_pkg;

  localparam int unsigned STNL_MAX_SYMBOLS = 1024;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned TYPE_W  = 5;
  localparam int unsigned TAG_W   = 10;

  localparam logic [TYPE_W-1:0] NN_EXT     = 5'd1;
  localparam logic [TYPE_W-1:0] CLASS_MASK = 5'o36;
  localparam logic [TYPE_W-1:0] NN_TEXT    = 5'd4;
  localparam logic [TYPE_W-1:0] NN_DATA    = 5'd6;
  localparam logic [TYPE_W-1:0] NN_BSS     = 5'd8;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  localparam logic [1:0] MODE_CODE     = 2'd0;
  localparam logic [1:0] MODE_SYMBOLIC = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_OUT_RANGE = 3'd2,
    ST_CODE      = 3'd3,
    ST_DATA      = 3'd4,
    ST_FALLBACK  = 3'd5,
    ST_NONE      = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAP_INIT,
    S_SORT_J,
    S_GAP_DOWN,
    S_RDA,
    S_RDB,
    S_CMP,
    S_WRB,
    S_BS_INIT,
    S_BS,
    S_BS_CMP,
    S_WALK,
    S_WALK_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [TYPE_W-1:0]  etype;
    logic [TAG_W-1:0]   tag;
  } entry_t;

endpackage

// ----- hw/rtl/stnl_mem.sv -----
// Symbol entry memory with one write port and one registered read port.
`timescale 1ns / 1ps
module stnl_mem import stnl_pkg::*; #(
  parameter int unsigned DEPTH = STNL_MAX_SYMBOLS,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/stnl_ctrl.sv -----
// Sequencer for loading, shell sorting and nearest-symbol search over the entry memory.
`timescale 1ns / 1ps
module stnl_ctrl import stnl_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = STNL_MAX_SYMBOLS,
  parameter int unsigned IW = $clog2(MAX_SYMBOLS),
  parameter int unsigned CW = $clog2(MAX_SYMBOLS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [VALUE_W-1:0] entry_value_i,
  input  logic [7:0]         entry_type_i,
  input  logic               last_entry_i,
  input  logic [VALUE_W-1:0] query_address_i,
  input  logic [1:0]         query_mode_i,
  input  logic [VALUE_W-1:0] start_address_i,
  input  logic [VALUE_W-1:0] end_address_i,
  output logic               res_ready_o,
  input  logic               res_free_i,
  output status_e            res_status_o,
  output logic [VALUE_W-1:0] res_value_o,
  output logic [TAG_W-1:0]   res_tag_o,
  output logic [VALUE_W-1:0] res_offset_o,
  output logic               mem_we_o,
  output logic [IW-1:0]      mem_waddr_o,
  output entry_t             mem_wdata_o,
  output logic [IW-1:0]      mem_raddr_o,
  input  entry_t             mem_rdata_i
);

  localparam int unsigned GW = CW + 2;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] gap_q, gap_d;
  logic [GW-1:0] h_q, h_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] i_q, i_d;
  entry_t a_q, a_d;
  logic signed [CW:0] lo_q, lo_d, hi_q, hi_d, k_q, k_d;
  logic [CW-1:0] mid_q, mid_d;
  logic want_code_q, want_code_d;
  logic sym_q, sym_d;
  logic [VALUE_W-1:0] addr_q, addr_d;
  status_e status_q, status_d;
  logic [VALUE_W-1:0] value_q, value_d, offset_q, offset_d;
  logic [TAG_W-1:0] tag_q, tag_d;

  logic [GW-1:0] h_next;
  logic [CW:0] mid_sum;
  logic [CW-1:0] i_gap;
  logic [TYPE_W-1:0] cls;
  logic match;

  assign h_next  = (h_q << 1) + h_q + GW'(1);
  assign mid_sum = {1'b0, lo_q[CW-1:0]} + {1'b0, hi_q[CW-1:0]};
  assign i_gap   = i_q + gap_q;
  assign cls     = mem_rdata_i.etype & CLASS_MASK;
  assign match   = ((mem_rdata_i.etype & NN_EXT) != '0) &&
                   (want_code_q ? (cls == NN_TEXT) : (cls == NN_DATA || cls == NN_BSS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gap_q       <= gap_d;
    h_q         <= h_d;
    j_q         <= j_d;
    i_q         <= i_d;
    a_q         <= a_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    k_q         <= k_d;
    mid_q       <= mid_d;
    want_code_q <= want_code_d;
    sym_q       <= sym_d;
    addr_q      <= addr_d;
    status_q    <= status_d;
    value_q     <= value_d;
    tag_q       <= tag_d;
    offset_q    <= offset_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    gap_d       = gap_q;
    h_d         = h_q;
    j_d         = j_q;
    i_d         = i_q;
    a_d         = a_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    k_d         = k_q;
    mid_d       = mid_q;
    want_code_d = want_code_q;
    sym_d       = sym_q;
    addr_d      = addr_q;
    status_d    = status_q;
    value_d     = value_q;
    tag_d       = tag_q;
    offset_d    = offset_q;
    in_stall_o  = 1'b1;
    res_ready_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          status_d = ST_ACCEPTED;
          value_d  = '0;
          tag_d    = '0;
          offset_d = '0;
          addr_d   = query_address_i;
          state_d  = S_DONE;
          unique case (op_e'(operation_i))
            OP_CLEAR: count_d = '0;
            OP_LOAD: begin
              if (count_q < CW'(MAX_SYMBOLS)) begin
                mem_we_o          = 1'b1;
                mem_waddr_o       = count_q[IW-1:0];
                mem_wdata_o.value = entry_value_i;
                mem_wdata_o.etype = entry_type_i[TYPE_W-1:0];
                mem_wdata_o.tag   = TAG_W'(count_q);
                count_d           = count_q + CW'(1);
              end else begin
                status_d = ST_FULL;
              end
              if (last_entry_i) begin
                gap_d   = CW'(1);
                h_d     = GW'(4);
                state_d = S_GAP_INIT;
              end
            end
            OP_QUERY: begin
              want_code_d = (query_mode_i == MODE_CODE) || (query_mode_i == MODE_SYMBOLIC);
              sym_d       = (query_mode_i == MODE_SYMBOLIC);
              if (query_mode_i == MODE_SYMBOLIC &&
                  (query_address_i < start_address_i || query_address_i > end_address_i)) begin
                status_d = ST_OUT_RANGE;
              end else begin
                state_d = S_BS_INIT;
              end
            end
            default: status_d = ST_ACCEPTED;
          endcase
        end
      end
      S_GAP_INIT: begin
        if (h_next < GW'(count_q)) begin
          gap_d = CW'(h_q);
          h_d   = h_next;
        end else begin
          j_d     = gap_q;
          state_d = S_SORT_J;
        end
      end
      S_SORT_J: begin
        if (j_q < count_q) begin
          i_d     = j_q - gap_q;
          state_d = S_RDA;
        end else if (gap_q == CW'(1)) begin
          state_d = S_DONE;
        end else begin
          h_d     = GW'(1);
          state_d = S_GAP_DOWN;
        end
      end
      S_GAP_DOWN: begin
        if (h_next < GW'(gap_q)) begin
          h_d = h_next;
        end else begin
          gap_d   = CW'(h_q);
          j_d     = CW'(h_q);
          state_d = S_SORT_J;
        end
      end
      S_RDA: begin
        mem_raddr_o = i_q[IW-1:0];
        state_d     = S_RDB;
      end
      S_RDB: begin
        a_d         = mem_rdata_i;
        mem_raddr_o = i_gap[IW-1:0];
        state_d     = S_CMP;
      end
      S_CMP: begin
        if (a_q.value <= mem_rdata_i.value) begin
          j_d     = j_q + CW'(1);
          state_d = S_SORT_J;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = i_q[IW-1:0];
          mem_wdata_o = mem_rdata_i;
          state_d     = S_WRB;
        end
      end
      S_WRB: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = i_gap[IW-1:0];
        mem_wdata_o = a_q;
        if (i_q >= gap_q) begin
          i_d     = i_q - gap_q;
          state_d = S_RDA;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = S_SORT_J;
        end
      end
      S_BS_INIT: begin
        lo_d    = '0;
        hi_d    = {1'b0, count_q} - {{CW{1'b0}}, 1'b1};
        state_d = S_BS;
      end
      S_BS: begin
        if (lo_q <= hi_q) begin
          mid_d       = mid_sum[CW:1];
          mem_raddr_o = mid_sum[IW:1];
          state_d     = S_BS_CMP;
        end else begin
          k_d     = hi_q;
          state_d = S_WALK;
        end
      end
      S_BS_CMP: begin
        if (addr_q < mem_rdata_i.value) begin
          hi_d = {1'b0, mid_q} - {{CW{1'b0}}, 1'b1};
        end else begin
          lo_d = {1'b0, mid_q} + {{CW{1'b0}}, 1'b1};
        end
        state_d = S_BS;
      end
      S_WALK: begin
        if (!k_q[CW]) begin
          mem_raddr_o = k_q[IW-1:0];
          state_d     = S_WALK_CHK;
        end else if (sym_q && want_code_q) begin
          want_code_d = 1'b0;
          k_d         = hi_q;
        end else if (sym_q) begin
          status_d = ST_FALLBACK;
          offset_d = addr_q - start_address_i;
          state_d  = S_DONE;
        end else begin
          status_d = ST_NONE;
          state_d  = S_DONE;
        end
      end
      S_WALK_CHK: begin
        if (match) begin
          status_d = want_code_q ? ST_CODE : ST_DATA;
          value_d  = mem_rdata_i.value;
          tag_d    = mem_rdata_i.tag;
          offset_d = addr_q - mem_rdata_i.value;
          state_d  = S_DONE;
        end else begin
          k_d     = k_q - {{CW{1'b0}}, 1'b1};
          state_d = S_WALK;
        end
      end
      S_DONE: begin
        if (res_free_i) begin
          res_ready_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_status_o = status_q;
  assign res_value_o  = value_q;
  assign res_tag_o    = tag_q;
  assign res_offset_o = offset_q;

endmodule

// ----- hw/rtl/symbol_table_nearest_lookup.sv -----
// Top level of the nearest-symbol lookup table: registers, output stage and memory.
`timescale 1ns / 1ps
// Usage: each input item is a clear, a load or a query. An item is taken when
// in_valid_i is high and in_stall_o is low; every item gives exactly one
// result item on the output channel, held in an output register until the
// receiver takes it with out_stall_i low. The output register lets the block
// accept the next item while a result still waits.
// A clear, a load and an out-of-range query go from idle to the done state,
// which passes the result on when the output is free. A load marked last
// then runs a shell sort: each position passes S_SORT_J, S_RDA, S_RDB and
// S_CMP, each swap adds S_WRB, each further compare repeats S_RDA, S_RDB and
// S_CMP, and gaps are set in S_GAP_INIT and S_GAP_DOWN. A query runs
// S_BS_INIT, a search of at most ceil(log2(N+1)) probes for N entries in
// S_BS and S_BS_CMP, and a backward walk in S_WALK and S_WALK_CHK; the
// symbolic mode may walk twice. The sequencer handles one item at a time.
// Reset clears the entry count, control state and output valid flag and sets
// the full address range; memory and other registers are not cleared. While
// the receiver stalls, the finished result holds and one more item can
// complete internally before the input side stalls too. The user writes
// start_address and end_address through the configuration port while the
// block is idle; the block itself does not enforce this.
module symbol_table_nearest_lookup import stnl_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = STNL_MAX_SYMBOLS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [VALUE_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [VALUE_W-1:0] entry_value_i,
  input  logic [7:0]         entry_type_i,
  input  logic               last_entry_i,
  input  logic [VALUE_W-1:0] query_address_i,
  input  logic [1:0]         query_mode_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [VALUE_W-1:0] symbol_value_o,
  output logic [TAG_W-1:0]   symbol_tag_o,
  output logic [VALUE_W-1:0] address_offset_o
);

  localparam int unsigned IW = $clog2(MAX_SYMBOLS);
  localparam int unsigned CW = $clog2(MAX_SYMBOLS + 1);

  logic [VALUE_W-1:0] start_q, end_q;
  logic out_valid_q;
  logic [2:0] status_q;
  logic [VALUE_W-1:0] value_q, offset_q;
  logic [TAG_W-1:0] tag_q;

  logic res_ready, res_free;
  status_e res_status;
  logic [VALUE_W-1:0] res_value, res_offset;
  logic [TAG_W-1:0] res_tag;
  logic mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata, mem_rdata;

  assign res_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      end_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_START: start_q <= cfg_data_i;
          CFG_END:   end_q   <= cfg_data_i;
          default:   start_q <= start_q;
        endcase
      end
      if (res_ready) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready) begin
      status_q <= res_status;
      value_q  <= res_value;
      tag_q    <= res_tag;
      offset_q <= res_offset;
    end
  end

  stnl_ctrl #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .IW(IW),
    .CW(CW)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .entry_value_i,
    .entry_type_i,
    .last_entry_i,
    .query_address_i,
    .query_mode_i,
    .start_address_i(start_q),
    .end_address_i  (end_q),
    .res_ready_o    (res_ready),
    .res_free_i     (res_free),
    .res_status_o   (res_status),
    .res_value_o    (res_value),
    .res_tag_o      (res_tag),
    .res_offset_o   (res_offset),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  stnl_mem #(
    .DEPTH(MAX_SYMBOLS),
    .AW(IW)
  ) u_mem (
    .clk_i,
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign symbol_value_o   = value_q;
  assign symbol_tag_o     = tag_q;
  assign address_offset_o = offset_q;

endmodule

// ----- tb/tb_symbol_table_nearest_lookup.sv -----
// Self-checking testbench for the nearest-symbol lookup table.
`timescale 1ns / 1ps
module tb_symbol_table_nearest_lookup;
  import stnl_pkg::*;

  localparam int unsigned DEPTH = STNL_MAX_SYMBOLS;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_ALT  = 2'd3;
  localparam int unsigned STALL_LIMIT = 3000000;
  localparam int unsigned ITEM_TARGET = 2000;

  typedef struct {
    op_e         op;
    logic [31:0] evalue;
    logic [7:0]  etype;
    logic        last;
    logic [31:0] addr;
    logic [1:0]  mode;
  } command_t;

  typedef struct {
    status_e     status;
    logic [31:0] value;
    logic [TAG_W-1:0] tag;
    logic [31:0] offset;
  } lookup_t;

  class symbol_scoreboard;
    logic [31:0]      values[DEPTH];
    logic [TYPE_W-1:0] types[DEPTH];
    logic [TAG_W-1:0] tags[DEPTH];
    int unsigned      count;
    logic [31:0]      start_addr;
    logic [31:0]      stop_addr;
    lookup_t          pending[$];
    int unsigned      errors;

    function void reset_state();
      count = 0;
      start_addr = '0;
      stop_addr = '1;
      errors = 0;
    endfunction

    function void swap_rows(int a, int b);
      logic [31:0] v;
      logic [TYPE_W-1:0] t;
      logic [TAG_W-1:0] g;
      v = values[a]; t = types[a]; g = tags[a];
      values[a] = values[b]; types[a] = types[b]; tags[a] = tags[b];
      values[b] = v; types[b] = t; tags[b] = g;
    endfunction

    function void shell_sort();
      int size;
      int gap;
      int h;
      size = count;
      gap = 1;
      h = 4;
      while (3 * h + 1 < size) begin
        gap = h;
        h = 3 * h + 1;
      end
      do begin
        for (int j = gap; j < size; j++) begin
          for (int i = j - gap; i >= 0; i -= gap) begin
            if (values[i] <= values[i + gap]) break;
            swap_rows(i, i + gap);
          end
        end
        gap = gap / 3;
      end while (gap != 0);
    endfunction

    function int nearest(logic [31:0] addr, bit want_code);
      int lo;
      int hi;
      int mid;
      logic [TYPE_W-1:0] cls;
      lo = 0;
      hi = int'(count) - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (addr < values[mid]) hi = mid - 1;
        else lo = mid + 1;
      end
      for (int k = hi; k >= 0; k--) begin
        cls = types[k] & CLASS_MASK;
        if ((types[k] & NN_EXT) == '0) continue;
        if (want_code ? (cls == NN_TEXT) : (cls == NN_DATA || cls == NN_BSS)) return k;
      end
      return -1;
    endfunction

    function void note_input(command_t c);
      lookup_t r;
      int k;
      r = '{ST_ACCEPTED, '0, '0, '0};
      if (c.op == OP_CLEAR) begin
        count = 0;
      end else if (c.op == OP_LOAD) begin
        if (count < DEPTH) begin
          values[count] = c.evalue;
          types[count] = c.etype[TYPE_W-1:0];
          tags[count] = count[TAG_W-1:0];
          count++;
        end else begin
          r.status = ST_FULL;
        end
        if (c.last) shell_sort();
      end else if (c.op == OP_QUERY) begin
        if (c.mode == MODE_SYMBOLIC) begin
          if (c.addr < start_addr || c.addr > stop_addr) begin
            r.status = ST_OUT_RANGE;
          end else begin
            k = nearest(c.addr, 1'b1);
            r.status = ST_CODE;
            if (k < 0) begin
              k = nearest(c.addr, 1'b0);
              r.status = ST_DATA;
            end
            if (k < 0) begin
              r.status = ST_FALLBACK;
              r.offset = c.addr - start_addr;
            end else begin
              r.value = values[k];
              r.tag = tags[k];
              r.offset = c.addr - values[k];
            end
          end
        end else begin
          k = nearest(c.addr, c.mode == MODE_CODE);
          if (k < 0) begin
            r.status = ST_NONE;
          end else begin
            r.status = (c.mode == MODE_CODE) ? ST_CODE : ST_DATA;
            r.value = values[k];
            r.tag = tags[k];
            r.offset = c.addr - values[k];
          end
        end
      end
      pending.push_back(r);
    endfunction

    task flag_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(lookup_t got);
      lookup_t want;
      if (pending.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status %0d", got.status));
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status)
        flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.value != want.value)
        flag_mismatch($sformatf("symbol_value %h, expected %h", got.value, want.value));
      if (got.tag != want.tag)
        flag_mismatch($sformatf("symbol_tag %0d, expected %0d", got.tag, want.tag));
      if (got.offset != want.offset)
        flag_mismatch($sformatf("address_offset %h, expected %h", got.offset, want.offset));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] operation_i = '0;
  logic [31:0] entry_value_i = '0;
  logic [7:0] entry_type_i = '0;
  logic last_entry_i = 1'b0;
  logic [31:0] query_address_i = '0;
  logic [1:0] query_mode_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [31:0] symbol_value_o;
  logic [TAG_W-1:0] symbol_tag_o;
  logic [31:0] address_offset_o;

  symbol_table_nearest_lookup u_dut (.*);

  symbol_scoreboard sb = new();
  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned stall_pct;
  int unsigned stall_hold;
  logic [31:0] value_pool[8];

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    command_t c;
    lookup_t r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      c.op = op_e'(operation_i);
      c.evalue = entry_value_i;
      c.etype = entry_type_i;
      c.last = last_entry_i;
      c.addr = query_address_i;
      c.mode = query_mode_i;
      sb.note_input(c);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      r.status = status_e'(status_o);
      r.value = symbol_value_o;
      r.tag = symbol_tag_o;
      r.offset = address_offset_o;
      sb.check_result(r);
    end
  end

  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 499) == 0) begin
      stall_hold = $urandom_range(10, 60);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send(command_t c, bit no_gap = 0);
    int unsigned gap;
    in_valid_i <= 1'b1;
    operation_i <= c.op;
    entry_value_i <= c.evalue;
    entry_type_i <= c.etype;
    last_entry_i <= c.last;
    query_address_i <= c.addr;
    query_mode_i <= c.mode;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic index, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == CFG_START) sb.start_addr = data;
    else sb.stop_addr = data;
    @(posedge clk_i);
  endtask

  function automatic command_t noise();
    command_t c;
    c.op = op_e'($urandom_range(0, 3));
    c.evalue = $urandom();
    c.etype = $urandom_range(0, 255);
    c.last = $urandom_range(0, 1);
    c.addr = $urandom();
    c.mode = $urandom_range(0, 3);
    return c;
  endfunction

  function automatic command_t load_cmd(logic [31:0] v, logic [7:0] t, logic last);
    command_t c;
    c = noise();
    c.op = OP_LOAD;
    c.evalue = v;
    c.etype = t;
    c.last = last;
    return c;
  endfunction

  function automatic command_t query_cmd(logic [31:0] a, logic [1:0] m);
    command_t c;
    c = noise();
    c.op = OP_QUERY;
    c.addr = a;
    c.mode = m;
    return c;
  endfunction

  function automatic command_t op_cmd(op_e op);
    command_t c;
    c = noise();
    c.op = op;
    return c;
  endfunction

  function automatic logic [7:0] random_type();
    logic [7:0] t;
    t = $urandom_range(0, 255);
    if ($urandom_range(0, 99) < 70) begin
      case ($urandom_range(0, 4))
        0: t[4:0] = NN_TEXT | NN_EXT;
        1: t[4:0] = NN_DATA | NN_EXT;
        2: t[4:0] = NN_BSS | NN_EXT;
        3: t[4:0] = 5'd2 | NN_EXT;
        default: t[0] = 1'b0;
      endcase
    end
    return t;
  endfunction

  function automatic logic [31:0] random_value(int unsigned style);
    case (style)
      0: return value_pool[$urandom_range(0, 7)];
      1: return $urandom_range(0, 4095);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] random_addr();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (sb.count > 0 && p < 60)
      return sb.values[$urandom_range(0, sb.count - 1)] + $urandom_range(0, 64) - 16;
    if (p < 65) return '0;
    if (p < 70) return '1;
    if (p < 85) return $urandom_range(0, 4095);
    return $urandom();
  endfunction

  task automatic run_table(int unsigned n, int unsigned style);
    for (int unsigned i = 0; i < n; i++)
      send(load_cmd(random_value(style), random_type(), i == n - 1));
  endtask

  initial begin
    int unsigned n;
    int unsigned style;
    int unsigned phase;
    sb.reset_state();
    items_sent = 0;
    idle_cycles = 0;
    stall_pct = 0;
    stall_hold = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extreme values, every class and mode, full range.
    send(query_cmd(32'h100, MODE_CODE));
    send(query_cmd(32'h100, MODE_SYMBOLIC));
    send(op_cmd(OP_NONE));
    send(op_cmd(OP_CLEAR));
    send(load_cmd(32'hFFFF_FFFF, 8'hFF, 1'b0));
    send(load_cmd(32'h0000_0000, NN_TEXT | NN_EXT, 1'b0));
    send(load_cmd(32'h0000_0200, NN_DATA | NN_EXT, 1'b0));
    send(load_cmd(32'h0000_0300, 8'hE0 | NN_BSS | NN_EXT, 1'b0));
    send(load_cmd(32'h0000_0100, NN_TEXT, 1'b0));
    send(load_cmd(32'h0000_0200, NN_TEXT | NN_EXT, 1'b1));
    send(query_cmd(32'h0000_0250, MODE_CODE));
    send(query_cmd(32'h0000_0250, MODE_DATA));
    send(query_cmd(32'h0000_0350, MODE_ALT));
    send(query_cmd(32'hFFFF_FFFF, MODE_SYMBOLIC));
    send(query_cmd(32'h0000_0000, MODE_DATA));
    send(load_cmd(32'h0000_0001, NN_BSS | NN_EXT, 1'b0));
    send(query_cmd(32'h0000_0010, MODE_DATA));
    send(op_cmd(OP_NONE));
    drain();
    write_reg(CFG_START, 32'h0000_0400);
    write_reg(CFG_END, 32'h0000_0800);
    send(query_cmd(32'h0000_03FF, MODE_SYMBOLIC));
    send(query_cmd(32'h0000_0801, MODE_SYMBOLIC));
    send(query_cmd(32'h0000_0500, MODE_SYMBOLIC));
    send(op_cmd(OP_CLEAR));
    send(load_cmd(32'h0000_0500, 8'h03, 1'b1));
    send(query_cmd(32'h0000_0600, MODE_SYMBOLIC));
    drain();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase % 3 == 0) begin
        case ($urandom_range(0, 3))
          0: begin write_reg(CFG_START, '0); write_reg(CFG_END, '1); end
          1: begin write_reg(CFG_START, '1); write_reg(CFG_END, '0); end
          2: begin
            write_reg(CFG_START, $urandom_range(0, 2048));
            write_reg(CFG_END, $urandom_range(2048, 8192));
          end
          default: begin write_reg(CFG_START, $urandom()); write_reg(CFG_END, $urandom()); end
        endcase
      end
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 10;
        2: stall_pct = 40;
        default: stall_pct = 80;
      endcase
      for (int i = 0; i < 8; i++) value_pool[i] = $urandom_range(0, 4095);
      style = $urandom_range(0, 2);
      send(op_cmd(OP_CLEAR));
      if (phase == 20) begin
        // Fill the table past capacity; the sort runs on the full table.
        stall_pct = 0;
        for (int unsigned i = 0; i < DEPTH + 2; i++)
          send(load_cmd($urandom(), random_type(), i == DEPTH + 1), 1'b1);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 120) : $urandom_range(1, 30);
        run_table(n, style);
        if ($urandom_range(0, 4) == 0)
          send(load_cmd(random_value(style), random_type(), 1'b0));
      end
      n = $urandom_range(10, 30);
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) send(noise());
        else send(query_cmd(random_addr(), $urandom_range(0, 3)));
      end
      drain();
      phase++;
    end

    if (sb.pending.size() == 0 && sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
